// ===== src/uart3x_pkg.sv =====
`timescale 1ns / 1ps

package uart3x_pkg;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_TICK = 2'd0;
    localparam cmd_t CMD_SEND = 2'd1;
    localparam cmd_t CMD_POP  = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_STOP = 2'd2;

    localparam logic [9:0] STOP_MARK     = 10'h200;
    localparam logic [3:0] FRAME_BITS    = 4'd10;
    localparam logic [3:0] DATA_BITS     = 4'd8;
    localparam logic [1:0] TX_TICKS_BIT  = 2'd3;
    localparam logic [2:0] RX_TICKS_BIT  = 3'd3;
    localparam logic [2:0] FIRST_SAMPLE  = 3'd4;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       send_accepted;
        logic       pop_valid;
        logic [7:0] pop_data;
        logic       rx_available;
    } rsp_t;

endpackage

// ===== src/uart3x_if.sv =====
`timescale 1ns / 1ps

interface uart3x_req_if import uart3x_pkg::*; ();
    logic       valid;
    logic       ready;
    cmd_t       cmd;
    logic       rx_level;
    logic [7:0] tx_data;

    modport source (output valid, cmd, rx_level, tx_data, input ready);
    modport sink (input valid, cmd, rx_level, tx_data, output ready);
endinterface

interface uart3x_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic       tx_busy;
    logic       send_accepted;
    logic       pop_valid;
    logic [7:0] pop_data;
    logic       rx_available;

    modport source (output valid, tx_line, tx_busy, send_accepted, pop_valid, pop_data,
                    rx_available, input ready);
    modport sink (input valid, tx_line, tx_busy, send_accepted, pop_valid, pop_data,
                  rx_available, output ready);
endinterface

// ===== src/uart3x_ram.sv =====
`timescale 1ns / 1ps

module uart3x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/uart_3x_oversample_transceiver.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Fields
// req      in   cmd[1:0], rx_level, tx_data[7:0]
// rsp      out  tx_line, tx_busy, send_accepted, pop_valid, pop_data[7:0], rx_available
//
// One item per cycle sustained while rsp is ready; each item passes the receive-buffer read, then the output register.
// The receive buffer is a BUF_DEPTH x 8 RAM with registered read; a pop reads it on accept.
// Reset clears all counters and pointers; buffer contents are unknown until written.
// A stalled rsp holds the output register; one more item is taken into the read stage.

module uart_3x_oversample_transceiver
    import uart3x_pkg::*;
#(
    parameter int BUF_DEPTH = 32
) (
    input logic           clk,
    input logic           rst_n,
    uart3x_req_if.sink    req,
    uart3x_rsp_if.source  rsp
);

    localparam int PW = $clog2(BUF_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(BUF_DEPTH - 1);

    logic [9:0]    tx_frame_reg, tx_frame_next;
    logic [1:0]    tx_tick_reg, tx_tick_next;
    logic [3:0]    tx_bits_reg, tx_bits_next;
    logic          tx_active_reg, tx_active_next;
    logic          tx_level_reg, tx_level_next;
    logic [1:0]    rx_phase_reg, rx_phase_next;
    logic [2:0]    rx_tick_reg, rx_tick_next;
    logic [3:0]    rx_bits_reg, rx_bits_next;
    logic [7:0]    rx_shift_reg, rx_shift_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;

    logic          acc;
    logic          push;
    logic          pop;
    logic          accepted;
    logic [2:0]    rx_tick_dec;
    logic [1:0]    tx_tick_dec;

    logic          s1_valid_reg;
    rsp_t          s1_reg, s1_next;
    logic [7:0]    ram_rdata;
    logic          move;
    logic          o_valid_reg;
    rsp_t          o_reg;

    assign move      = !o_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || move;
    assign acc       = req.valid && req.ready;

    always_comb
    begin
        tx_frame_next = tx_frame_reg;
        tx_tick_next  = tx_tick_reg;
        tx_bits_next  = tx_bits_reg;
        tx_active_next = tx_active_reg;
        tx_level_next = tx_level_reg;
        rx_phase_next = rx_phase_reg;
        rx_tick_next  = rx_tick_reg;
        rx_bits_next  = rx_bits_reg;
        rx_shift_next = rx_shift_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        push          = 1'b0;
        pop           = 1'b0;
        accepted      = 1'b0;
        tx_tick_dec   = tx_tick_reg - 2'd1;
        rx_tick_dec   = rx_tick_reg - 3'd1;

        if (acc)
        begin
            case (req.cmd)
                CMD_TICK:
                begin
                    if (tx_active_reg)
                    begin
                        tx_tick_next = tx_tick_dec;
                        if (tx_tick_dec == 2'd0)
                        begin
                            tx_level_next = tx_frame_reg[0];
                            tx_frame_next = {1'b0, tx_frame_reg[9:1]};
                            tx_tick_next  = TX_TICKS_BIT;
                            tx_bits_next  = tx_bits_reg - 4'd1;
                            if (tx_bits_reg == 4'd1)
                            begin
                                tx_active_next = 1'b0;
                            end
                        end
                    end
                    case (rx_phase_reg)
                        PH_STOP:
                        begin
                            rx_tick_next = rx_tick_dec;
                            if (rx_tick_dec == 3'd0)
                            begin
                                rx_phase_next = PH_IDLE;
                                push          = 1'b1;
                                wr_ptr_next   = (wr_ptr_reg == PTR_LAST) ? '0
                                                : wr_ptr_reg + PW'(1);
                            end
                        end
                        PH_DATA:
                        begin
                            rx_tick_next = rx_tick_dec;
                            if (rx_tick_dec == 3'd0)
                            begin
                                rx_tick_next = RX_TICKS_BIT;
                                if (req.rx_level)
                                begin
                                    rx_shift_next[3'(DATA_BITS - rx_bits_reg)] = 1'b1;
                                end
                                rx_bits_next = rx_bits_reg - 4'd1;
                                if (rx_bits_reg == 4'd1)
                                begin
                                    rx_phase_next = PH_STOP;
                                end
                            end
                        end
                        default:
                        begin
                            if (!req.rx_level && rx_phase_reg == PH_IDLE)
                            begin
                                rx_phase_next = PH_DATA;
                                rx_shift_next = 8'd0;
                                rx_tick_next  = FIRST_SAMPLE;
                                rx_bits_next  = DATA_BITS;
                            end
                        end
                    endcase
                end
                CMD_SEND:
                begin
                    if (!tx_active_reg)
                    begin
                        tx_tick_next   = TX_TICKS_BIT;
                        tx_bits_next   = FRAME_BITS;
                        tx_frame_next  = {1'b0, req.tx_data, 1'b0} | STOP_MARK;
                        tx_active_next = 1'b1;
                        accepted       = 1'b1;
                    end
                end
                CMD_POP:
                begin
                    if (wr_ptr_reg != rd_ptr_reg)
                    begin
                        pop         = 1'b1;
                        rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        s1_next.tx_line       = tx_level_next;
        s1_next.tx_busy       = tx_active_next;
        s1_next.send_accepted = accepted;
        s1_next.pop_valid     = pop;
        s1_next.pop_data      = 8'd0;
        s1_next.rx_available  = (wr_ptr_next != rd_ptr_next);
    end

    uart3x_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_rx_store (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (rx_shift_reg),
        .re    (pop),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_frame_reg  <= '0;
            tx_tick_reg   <= '0;
            tx_bits_reg   <= '0;
            tx_active_reg <= 1'b0;
            tx_level_reg  <= 1'b1;
            rx_phase_reg  <= PH_IDLE;
            rx_tick_reg   <= '0;
            rx_bits_reg   <= '0;
            rx_shift_reg  <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            o_valid_reg   <= 1'b0;
        end
        else
        begin
            tx_frame_reg  <= tx_frame_next;
            tx_tick_reg   <= tx_tick_next;
            tx_bits_reg   <= tx_bits_next;
            tx_active_reg <= tx_active_next;
            tx_level_reg  <= tx_level_next;
            rx_phase_reg  <= rx_phase_next;
            rx_tick_reg   <= rx_tick_next;
            rx_bits_reg   <= rx_bits_next;
            rx_shift_reg  <= rx_shift_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (move)
            begin
                o_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_reg <= s1_next;
        end
        if (move && s1_valid_reg)
        begin
            o_reg <= {s1_reg.tx_line, s1_reg.tx_busy, s1_reg.send_accepted, s1_reg.pop_valid,
                      s1_reg.pop_valid ? ram_rdata : 8'd0, s1_reg.rx_available};
        end
    end

    assign rsp.valid         = o_valid_reg;
    assign rsp.tx_line       = o_reg.tx_line;
    assign rsp.tx_busy       = o_reg.tx_busy;
    assign rsp.send_accepted = o_reg.send_accepted;
    assign rsp.pop_valid     = o_reg.pop_valid;
    assign rsp.pop_data      = o_reg.pop_data;
    assign rsp.rx_available  = o_reg.rx_available;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !move |=> s1_valid_reg)
        else $error("read stage item dropped under stall");

    a_tx_end_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(tx_active_reg) |-> $past(acc && req.cmd == CMD_TICK))
        else $error("transmitter stopped outside a tick");

    a_wr_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(wr_ptr_reg) |-> $past(acc && req.cmd == CMD_TICK && rx_phase_reg == PH_STOP))
        else $error("write pointer moved without a receive push");

    a_rd_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(rd_ptr_reg) |-> $past(acc && req.cmd == CMD_POP && wr_ptr_reg != rd_ptr_reg))
        else $error("read pointer moved without a valid pop");

    a_send_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |-> !tx_active_reg && tx_active_next)
        else $error("send taken while transmitter busy");

endmodule
